// ===== rtl/core/rclc_pkg.sv =====
// Shared types, constants and helpers for the rover command-line controller.
// Depends on nothing; imported by rclc_char_unit, the core and the testbench.
package rclc_pkg;

  localparam int unsigned LINE_CAP_DEF = 64;

  localparam logic [7:0]  ANGLE_MAX       = 8'd180;
  localparam logic [7:0]  GRIP_THRESHOLD  = 8'd90;
  localparam logic [7:0]  SPEED_LIMIT     = 8'd255;
  localparam logic [15:0] NUM_SAT         = 16'hFFFF;
  localparam logic [7:0]  DRIVE_SPEED_RST = 8'd250;
  localparam logic [15:0] CLOSE_RUN_RST   = 16'd600;
  localparam logic [15:0] OPEN_RUN_RST    = 16'd800;
  localparam logic [15:0] WATCHDOG_RST    = 16'd2000;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_COMMA = 8'h2C;

  // register indexes
  localparam logic [1:0] CFG_CLOSE_RUN = 2'd0;
  localparam logic [1:0] CFG_OPEN_RUN  = 2'd1;
  localparam logic [1:0] CFG_WATCHDOG  = 2'd2;

  // reply codes
  localparam logic [3:0] RC_NONE  = 4'd0;
  localparam logic [3:0] RC_HOME  = 4'd10;
  localparam logic [3:0] RC_ARM   = 4'd11;
  localparam logic [3:0] RC_SPEED = 4'd12;
  localparam logic [3:0] RC_FMT   = 4'd13;
  localparam logic [3:0] RC_EMPTY = 4'd14;
  localparam logic [3:0] RC_OVF   = 4'd15;

  // gripper codes
  localparam logic [3:0] GC_NONE        = 4'd0;
  localparam logic [3:0] GC_CLOSING     = 4'd1;
  localparam logic [3:0] GC_OPENING     = 4'd2;
  localparam logic [3:0] GC_ALR_CLOSED  = 4'd3;
  localparam logic [3:0] GC_ALR_OPEN    = 4'd4;
  localparam logic [3:0] GC_CLOSED      = 4'd5;
  localparam logic [3:0] GC_OPENED      = 4'd6;
  localparam logic [3:0] GC_CLOSED_TO   = 4'd7;
  localparam logic [3:0] GC_OPENED_TO   = 4'd8;

  // gripper drive
  localparam logic [1:0] GD_STOP  = 2'd0;
  localparam logic [1:0] GD_CLOSE = 2'd1;
  localparam logic [1:0] GD_OPEN  = 2'd2;

  typedef enum logic [1:0] {
    PH_BLANK = 2'd0,
    PH_DIGIT = 2'd1,
    PH_END   = 2'd2
  } parse_phase_e;

  typedef struct packed {
    parse_phase_e phase;
    logic         neg;
    logic [15:0]  acc;
  } parse_t;

  localparam parse_t PARSE_INIT = '{phase: PH_BLANK, neg: 1'b0, acc: 16'd0};

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // 0 when not a drive letter, else 1..9
  function automatic logic [3:0] drive_index(input logic [7:0] c);
    logic [3:0] r;
    unique case (c)
      "F":     r = 4'd1;
      "B":     r = 4'd2;
      "L":     r = 4'd3;
      "R":     r = 4'd4;
      "W":     r = 4'd5;
      "H":     r = 4'd6;
      "J":     r = 4'd7;
      "G":     r = 4'd8;
      "I":     r = 4'd9;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  // bit0 right fwd, bit1 right back, bit2 left fwd, bit3 left back
  function automatic logic [3:0] drive_mask(input logic [3:0] idx);
    logic [3:0] m;
    unique case (idx)
      4'd1:    m = 4'h5;
      4'd2:    m = 4'hA;
      4'd3:    m = 4'h9;
      4'd4:    m = 4'h6;
      4'd6:    m = 4'h1;
      4'd7:    m = 4'h4;
      4'd8:    m = 4'h2;
      4'd9:    m = 4'h8;
      default: m = 4'h0;
    endcase
    return m;
  endfunction

  function automatic logic hdr_match(input logic [1:0] pos, input logic [7:0] c,
                                     input logic is_arm);
    logic [7:0] e;
    unique case (pos)
      2'd0:    e = is_arm ? 8'h41 : 8'h53;  // A / S
      2'd1:    e = is_arm ? 8'h52 : 8'h50;  // R / P
      2'd2:    e = is_arm ? 8'h4D : 8'h44;  // M / D
      default: e = 8'h3A;                   // colon
    endcase
    return c == e;
  endfunction

  function automatic logic [7:0] clamp8(input parse_t p, input logic [7:0] hi);
    logic [7:0] r;
    if (p.neg) r = 8'd0;
    else if (p.acc > {8'd0, hi}) r = hi;
    else r = p.acc[7:0];
    return r;
  endfunction

endpackage

// ===== rtl/core/rclc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rclc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/core/rclc_char_unit.sv =====
// Shared per-character number parser step (atol rules, saturating).
// Depends on rclc_pkg.
module rclc_char_unit
  import rclc_pkg::*;
(
  input  logic [7:0] char_i,
  input  parse_t     state_i,
  output parse_t     state_o
);

  logic        digit;
  logic [3:0]  dval;
  logic [19:0] prod;
  logic [15:0] acc_sat;

  assign digit   = (char_i >= 8'h30) && (char_i <= 8'h39);
  assign dval    = 4'(char_i - 8'h30);
  // acc*10 + d as two shifted adds
  assign prod    = {1'b0, state_i.acc, 3'b000} + {3'b000, state_i.acc, 1'b0} + {16'd0, dval};
  assign acc_sat = (prod > {4'd0, NUM_SAT}) ? NUM_SAT : prod[15:0];

  always_comb begin
    state_o = state_i;
    unique case (state_i.phase)
      PH_BLANK: begin
        if (is_blank(char_i)) begin
          state_o.phase = PH_BLANK;
        end else if (char_i == 8'h2B || char_i == 8'h2D) begin
          state_o.neg   = (char_i == 8'h2D);
          state_o.phase = PH_DIGIT;
        end else if (digit) begin
          state_o.acc   = acc_sat;
          state_o.phase = PH_DIGIT;
        end else begin
          state_o.phase = PH_END;
        end
      end
      PH_DIGIT: begin
        if (digit) state_o.acc = acc_sat;
        else state_o.phase = PH_END;
      end
      default: state_o.phase = PH_END;
    endcase
  end

endmodule

// ===== rtl/core/rover_command_line_controller_core.sv =====
// Rover command-line controller: top level with sequencer, line stores and state.
// Depends on rclc_pkg, rclc_ram and rclc_char_unit.
//
// Usage:
//  - Request channel (in_valid_i/in_ready_o): func_i=0 carries a received byte
//    (rx_byte_i) for port source_port_i, func_i=1 carries a tick of tick_ms_i ms.
//  - Result channel (out_valid_o/out_ready_i): one result per request, holding
//    the reply and gripper codes plus a snapshot of all drive/arm/gripper state.
//  - Config channel (cfg_valid_i/cfg_ready_o): always ready; index 0 close run,
//    1 open run, 2 watchdog (ms). Other indexes are ignored.
//  - Sequencing: a plain byte or a tick goes from acceptance through dispatch
//    to a load into the result register. A CR/LF walks the stored line twice
//    through the line RAM: a trim pass over the whole line, a decode pass over
//    the trimmed line, then an execute step. One request is in work at a time;
//    in_ready_o is high only when idle, in the cycle after the result is loaded,
//    so a new byte or tick is taken only once the last one is through.
//  - The result register frees the core: a new request may be taken while a
//    result waits. If the receiver stalls, the next request finishes its work
//    and waits in its final state until the output register is taken.
//  - Reset: line lengths zero, speed 250, PWM and angles zero, gripper open and
//    stopped, timings back to 600/800/2000 ms. Line RAM contents are not reset.
module rover_command_line_controller_core
  import rclc_pkg::*;
#(
  parameter int unsigned LINE_CAPACITY = LINE_CAP_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        func_i,
  input  logic        source_port_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [15:0] tick_ms_i,

  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  reply_code_o,
  output logic [3:0]  grip_code_o,
  output logic        reply_port_o,
  output logic [7:0]  pwm_right_fwd_o,
  output logic [7:0]  pwm_right_back_o,
  output logic [7:0]  pwm_left_fwd_o,
  output logic [7:0]  pwm_left_back_o,
  output logic [7:0]  base_angle_out_o,
  output logic [7:0]  elbow_angle_out_o,
  output logic [1:0]  gripper_drive_o,
  output logic        gripper_is_closed_o,
  output logic [7:0]  speed_out_o,

  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned IW = $clog2(LINE_CAPACITY);      // RAM index bits per port
  localparam int unsigned LW = $clog2(LINE_CAPACITY + 1);  // length counter bits
  localparam int unsigned AW = IW + 1;
  localparam logic [LW-1:0] CAP = LW'(LINE_CAPACITY);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DISP = 6'b000010,
    S_TRIM = 6'b000100,
    S_DEC  = 6'b001000,
    S_EXEC = 6'b010000,
    S_FIN  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [15:0] close_q, open_q, wdog_q;

  // latched request
  logic        func_q, port_q;
  logic [7:0]  byte_q;
  logic [15:0] tick_q;

  // architectural state
  logic [LW-1:0] len_q [2];
  logic [LW-1:0] len_d [2];
  logic [7:0]    speed_q, speed_d;
  logic [7:0]    pwm_q [4];
  logic [7:0]    pwm_d [4];
  logic [7:0]    base_q, base_d, elbow_q, elbow_d;
  logic          gclosed_q, gclosed_d, grun_q, grun_d, gclosing_q, gclosing_d;
  logic          gport_q, gport_d;
  logic [15:0]   gelap_q, gelap_d;

  // scan control
  logic [LW-1:0] idx_q, idx_d, end_q, end_d, didx_q, didx_d;
  logic          dv_q, dv_d;
  logic [LW-1:0] st_q, st_d, en_q, en_d;
  logic          found_q, found_d;

  // decode state
  logic          arm_q, arm_d, spd_q, spd_d;
  logic [7:0]    first_q, first_d;
  parse_t        ps_q, ps_d, fv0_q, fv0_d, fv1_q, fv1_d, ps_next;
  logic [1:0]    fcnt_q, fcnt_d;
  logic [2:0]    ne_q, ne_d;

  // result
  logic [3:0]    rc_q, rc_d, gc_q, gc_d;
  logic          rport_q, rport_d;
  logic          out_valid_q;

  // line RAM
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_rdata;

  logic          issue, scan_done, is_term;
  logic [LW-1:0] pos, nlen;
  logic [16:0]   sum;
  logic [15:0]   run_ms;
  logic [3:0]    di;
  logic [3:0]    dmask;
  parse_t        val0, val1;
  logic [7:0]    gval;
  logic          out_load;

  assign is_term   = (byte_q == CH_LF) || (byte_q == CH_CR);
  assign issue     = idx_q < end_q;
  assign scan_done = !issue && !dv_q;
  assign pos       = didx_q - st_q;
  assign nlen      = en_q - st_q;
  assign sum       = {1'b0, gelap_q} + {1'b0, tick_q};
  assign run_ms    = gclosing_q ? close_q : open_q;
  assign di        = drive_index(first_q);
  assign dmask     = drive_mask(di);
  assign val0      = (fcnt_q == 2'd0) ? ps_q : fv0_q;
  assign val1      = (fcnt_q == 2'd1) ? ps_q : fv1_q;
  assign gval      = clamp8(ps_q, ANGLE_MAX);
  assign out_load  = (state_q == S_FIN) && (!out_valid_q || out_ready_i);

  assign ram_we    = (state_q == S_DISP) && !func_q && !is_term && (len_q[port_q] < CAP);
  assign ram_waddr = {port_q, len_q[port_q][IW-1:0]};
  assign ram_raddr = {port_q, idx_q[IW-1:0]};

  rclc_ram #(
    .WIDTH(8),
    .DEPTH(2 << IW)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(byte_q),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // the one parser step, reused for every character of every field
  rclc_char_unit u_char_unit (
    .char_i (ram_rdata),
    .state_i(ps_q),
    .state_o(ps_next)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d    = state_q;
    len_d[0]   = len_q[0];
    len_d[1]   = len_q[1];
    speed_d    = speed_q;
    for (int k = 0; k < 4; k++) pwm_d[k] = pwm_q[k];
    base_d     = base_q;
    elbow_d    = elbow_q;
    gclosed_d  = gclosed_q;
    grun_d     = grun_q;
    gclosing_d = gclosing_q;
    gport_d    = gport_q;
    gelap_d    = gelap_q;
    idx_d      = idx_q;
    end_d      = end_q;
    didx_d     = didx_q;
    dv_d       = 1'b0;
    st_d       = st_q;
    en_d       = en_q;
    found_d    = found_q;
    arm_d      = arm_q;
    spd_d      = spd_q;
    first_d    = first_q;
    ps_d       = ps_q;
    fv0_d      = fv0_q;
    fv1_d      = fv1_q;
    fcnt_d     = fcnt_q;
    ne_d       = ne_q;
    rc_d       = rc_q;
    gc_d       = gc_q;
    rport_d    = rport_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DISP;
      end

      S_DISP: begin
        rc_d    = RC_NONE;
        gc_d    = GC_NONE;
        state_d = S_FIN;
        if (func_q) begin
          rport_d = gport_q;
          if (grun_q) begin
            gelap_d = sum[16] ? NUM_SAT : sum[15:0];
            if (sum > {1'b0, wdog_q}) begin
              grun_d    = 1'b0;
              gclosed_d = gclosing_q;
              gc_d      = gclosing_q ? GC_CLOSED_TO : GC_OPENED_TO;
            end else if (sum >= {1'b0, run_ms}) begin
              grun_d    = 1'b0;
              gclosed_d = gclosing_q;
              gc_d      = gclosing_q ? GC_CLOSED : GC_OPENED;
            end
          end
        end else begin
          rport_d = port_q;
          if (is_term) begin
            len_d[port_q] = '0;
            idx_d   = '0;
            end_d   = len_q[port_q];
            found_d = 1'b0;
            state_d = S_TRIM;
          end else if (len_q[port_q] < CAP) begin
            len_d[port_q] = len_q[port_q] + LW'(1);
          end else begin
            len_d[port_q] = '0;
            rc_d = RC_OVF;
          end
        end
      end

      S_TRIM: begin
        if (issue) begin
          idx_d = idx_q + LW'(1);
          dv_d  = 1'b1;
        end
        didx_d = idx_q;
        if (dv_q && !is_blank(ram_rdata)) begin
          if (!found_q) begin
            st_d    = didx_q;
            found_d = 1'b1;
          end
          en_d = didx_q + LW'(1);
        end
        if (scan_done) begin
          if (!found_q) begin
            state_d = S_FIN;  // blank line
          end else begin
            idx_d   = st_q;
            end_d   = en_q;
            arm_d   = 1'b1;
            spd_d   = 1'b1;
            ps_d    = PARSE_INIT;
            fcnt_d  = 2'd0;
            ne_d    = 3'b000;
            state_d = S_DEC;
          end
        end
      end

      S_DEC: begin
        if (issue) begin
          idx_d = idx_q + LW'(1);
          dv_d  = 1'b1;
        end
        didx_d = idx_q;
        if (dv_q) begin
          if (pos == '0) first_d = ram_rdata;
          if (pos < LW'(4)) begin
            arm_d = arm_q && hdr_match(pos[1:0], ram_rdata, 1'b1);
            spd_d = spd_q && hdr_match(pos[1:0], ram_rdata, 1'b0);
          end else if (ram_rdata == CH_COMMA && fcnt_q != 2'd2) begin
            if (fcnt_q == 2'd0) fv0_d = ps_q;
            else fv1_d = ps_q;
            fcnt_d = fcnt_q + 2'd1;
            ps_d   = PARSE_INIT;
          end else begin
            ps_d = ps_next;
            ne_d[fcnt_q] = 1'b1;
          end
        end
        if (scan_done) state_d = S_EXEC;
      end

      S_EXEC: begin
        state_d = S_FIN;
        if (nlen >= LW'(4) && arm_q) begin
          if (fcnt_q != 2'd2 || !ne_q[2]) begin
            rc_d = RC_FMT;
          end else if (!ne_q[0] || !ne_q[1]) begin
            rc_d = RC_EMPTY;
          end else begin
            rc_d    = RC_ARM;
            base_d  = clamp8(val0, ANGLE_MAX);
            elbow_d = clamp8(val1, ANGLE_MAX);
            if (gval >= GRIP_THRESHOLD && !gclosed_q) begin
              grun_d = 1'b1; gclosing_d = 1'b1; gelap_d = '0; gport_d = port_q;
              gc_d   = GC_CLOSING;
            end else if (gval < GRIP_THRESHOLD && gclosed_q) begin
              grun_d = 1'b1; gclosing_d = 1'b0; gelap_d = '0; gport_d = port_q;
              gc_d   = GC_OPENING;
            end
          end
        end else if (nlen >= LW'(4) && spd_q) begin
          speed_d = clamp8(val0, SPEED_LIMIT);
          rc_d    = RC_SPEED;
        end else if (nlen == LW'(1)) begin
          if (di != 4'd0) begin
            for (int k = 0; k < 4; k++) pwm_d[k] = dmask[k] ? speed_q : 8'd0;
            rc_d = di;
          end else if (first_q == 8'h50) begin  // P: home
            base_d  = '0;
            elbow_d = '0;
            rc_d    = RC_HOME;
          end else if (first_q == 8'h4F) begin  // O: open
            if (!gclosed_q) begin
              gc_d = GC_ALR_OPEN;
            end else begin
              grun_d = 1'b1; gclosing_d = 1'b0; gelap_d = '0; gport_d = port_q;
              gc_d   = GC_OPENING;
            end
          end else if (first_q == 8'h43) begin  // C: close
            if (gclosed_q) begin
              gc_d = GC_ALR_CLOSED;
            end else begin
              grun_d = 1'b1; gclosing_d = 1'b1; gelap_d = '0; gport_d = port_q;
              gc_d   = GC_CLOSING;
            end
          end
        end
      end

      S_FIN: begin
        if (out_load) state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      close_q     <= CLOSE_RUN_RST;
      open_q      <= OPEN_RUN_RST;
      wdog_q      <= WATCHDOG_RST;
      len_q[0]    <= '0;
      len_q[1]    <= '0;
      speed_q     <= DRIVE_SPEED_RST;
      for (int k = 0; k < 4; k++) pwm_q[k] <= '0;
      base_q      <= '0;
      elbow_q     <= '0;
      gclosed_q   <= 1'b0;
      grun_q      <= 1'b0;
      gclosing_q  <= 1'b0;
      gport_q     <= 1'b0;
      gelap_q     <= '0;
      dv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      len_q[0]   <= len_d[0];
      len_q[1]   <= len_d[1];
      speed_q    <= speed_d;
      for (int k = 0; k < 4; k++) pwm_q[k] <= pwm_d[k];
      base_q     <= base_d;
      elbow_q    <= elbow_d;
      gclosed_q  <= gclosed_d;
      grun_q     <= grun_d;
      gclosing_q <= gclosing_d;
      gport_q    <= gport_d;
      gelap_q    <= gelap_d;
      dv_q       <= dv_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_CLOSE_RUN: close_q <= cfg_data_i;
          CFG_OPEN_RUN:  open_q  <= cfg_data_i;
          CFG_WATCHDOG:  wdog_q  <= cfg_data_i;
          default:       ;
        endcase
      end
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      func_q <= func_i;
      port_q <= source_port_i;
      byte_q <= rx_byte_i;
      tick_q <= tick_ms_i;
    end
    idx_q   <= idx_d;
    end_q   <= end_d;
    didx_q  <= didx_d;
    st_q    <= st_d;
    en_q    <= en_d;
    found_q <= found_d;
    arm_q   <= arm_d;
    spd_q   <= spd_d;
    first_q <= first_d;
    ps_q    <= ps_d;
    fv0_q   <= fv0_d;
    fv1_q   <= fv1_d;
    fcnt_q  <= fcnt_d;
    ne_q    <= ne_d;
    rc_q    <= rc_d;
    gc_q    <= gc_d;
    rport_q <= rport_d;
    if (out_load) begin
      reply_code_o        <= rc_q;
      grip_code_o         <= gc_q;
      reply_port_o        <= rport_q;
      pwm_right_fwd_o     <= pwm_q[0];
      pwm_right_back_o    <= pwm_q[1];
      pwm_left_fwd_o      <= pwm_q[2];
      pwm_left_back_o     <= pwm_q[3];
      base_angle_out_o    <= base_q;
      elbow_angle_out_o   <= elbow_q;
      gripper_drive_o     <= grun_q ? (gclosing_q ? GD_CLOSE : GD_OPEN) : GD_STOP;
      gripper_is_closed_o <= gclosed_q;
      speed_out_o         <= speed_q;
    end
  end

  // an accepted request always leaves idle on the next edge
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_DISP))
    else $error("request accepted but sequencer did not start");

  // line lengths never exceed the store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_q[0] <= CAP) && (len_q[1] <= CAP))
    else $error("line length beyond capacity");

  // angles stay clamped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (base_q <= ANGLE_MAX) && (elbow_q <= ANGLE_MAX))
    else $error("arm angle out of range");

  // a result is loaded only when the output register is free or being drained
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i && state_q == S_FIN) |=> (state_q == S_FIN))
    else $error("result overwritten while stalled");

endmodule

// ===== verif/tb.sv =====
// Testbench for the rover command-line controller core: line assembly, command
// decode, gripper timing and register writes, checked against a behavioral model.
// Depends on rclc_pkg and the core RTL.
module tb;
  import rclc_pkg::*;

  localparam int LINE_CAP = 64;
  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        func_i = 1'b0;
  logic        source_port_i = 1'b0;
  logic [7:0]  rx_byte_i = 8'd0;
  logic [15:0] tick_ms_i = 16'd0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [3:0]  reply_code_o, grip_code_o;
  logic        reply_port_o;
  logic [7:0]  pwm_right_fwd_o, pwm_right_back_o, pwm_left_fwd_o, pwm_left_back_o;
  logic [7:0]  base_angle_out_o, elbow_angle_out_o, speed_out_o;
  logic [1:0]  gripper_drive_o;
  logic        gripper_is_closed_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = 2'd0;
  logic [15:0] cfg_data_i = 16'd0;

  rover_command_line_controller_core u_dut (.*);

  // One snapshot of the block's reply, field for field as on the ports.
  typedef struct packed {
    logic [3:0] reply;
    logic [3:0] grip;
    logic       port;
    logic [7:0] rf, rb, lf, lb;
    logic [7:0] base, elbow;
    logic [1:0] drive;
    logic       closed;
    logic [7:0] speed;
  } reply_t;

  reply_t expected_replies[$];
  int     mismatches = 0;
  int     requests_sent = 0;
  int     replies_seen = 0;
  int     idle_cycles = 0;
  bit     timed_out = 1'b0;

  // Model state mirrors what the block holds between requests.
  logic [15:0] m_close_run, m_open_run, m_watchdog;
  logic [7:0]  m_line[2][LINE_CAP];
  int          m_len[2];
  logic [7:0]  m_speed;
  logic [7:0]  m_pwm[4];
  logic [7:0]  m_base, m_elbow;
  logic        m_closed, m_running, m_closing, m_gport;
  logic [15:0] m_elapsed;

  initial begin : clock_gen
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit blank_ch(logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // Decimal field read the atol way, then clamped to 0..hi.
  function automatic logic [7:0] read_number(int p, int s, int n, int hi);
    int i, acc;
    bit neg;
    i = 0; acc = 0; neg = 0;
    while (i < n && blank_ch(m_line[p][s+i])) i++;
    if (i < n && (m_line[p][s+i] == "+" || m_line[p][s+i] == "-")) begin
      neg = m_line[p][s+i] == "-";
      i++;
    end
    while (i < n && m_line[p][s+i] >= "0" && m_line[p][s+i] <= "9") begin
      acc = acc * 10 + (m_line[p][s+i] - "0");
      if (acc > 65535) acc = 65535;
      i++;
    end
    if (neg) return 8'd0;
    return (acc > hi) ? hi[7:0] : acc[7:0];
  endfunction

  function automatic logic [3:0] grip_close_start(logic p);
    if (m_closed) return GC_ALR_CLOSED;
    m_running = 1; m_closing = 1; m_elapsed = 0; m_gport = p;
    return GC_CLOSING;
  endfunction

  function automatic logic [3:0] grip_open_start(logic p);
    if (!m_closed) return GC_ALR_OPEN;
    m_running = 1; m_closing = 0; m_elapsed = 0; m_gport = p;
    return GC_OPENING;
  endfunction

  function automatic bit header_is(int p, int s, string h);
    for (int k = 0; k < 4; k++) if (m_line[p][s+k] != h[k]) return 0;
    return 1;
  endfunction

  // Decode the trimmed line m_line[p][s .. s+n).
  task automatic run_command(int p, int s, int n, inout reply_t r);
    int v, len, c1, c2;
    logic [7:0] g, ch;
    logic [3:0] idx, msk;
    if (n >= 4 && header_is(p, s, "ARM:")) begin
      v = s + 4; len = n - 4; c1 = len; c2 = len;
      for (int i = 0; i < len; i++) if (m_line[p][v+i] == CH_COMMA) begin c1 = i; break; end
      if (c1 < len)
        for (int i = c1 + 1; i < len; i++)
          if (m_line[p][v+i] == CH_COMMA) begin c2 = i; break; end
      if (c1 >= len || c2 >= len || c2 + 1 >= len) begin r.reply = RC_FMT; return; end
      if (c1 == 0 || c2 == c1 + 1) begin r.reply = RC_EMPTY; return; end
      m_base  = read_number(p, v, c1, 180);
      m_elbow = read_number(p, v + c1 + 1, c2 - c1 - 1, 180);
      g = read_number(p, v + c2 + 1, len - c2 - 1, 180);
      if (g >= GRIP_THRESHOLD && !m_closed) r.grip = grip_close_start(p[0]);
      else if (g < GRIP_THRESHOLD && m_closed) r.grip = grip_open_start(p[0]);
      r.reply = RC_ARM;
      return;
    end
    if (n >= 4 && header_is(p, s, "SPD:")) begin
      m_speed = read_number(p, s + 4, n - 4, 255);
      r.reply = RC_SPEED;
      return;
    end
    if (n != 1) return;
    ch = m_line[p][s];
    case (ch)
      "F": begin idx = 1; msk = 4'h5; end
      "B": begin idx = 2; msk = 4'hA; end
      "L": begin idx = 3; msk = 4'h9; end
      "R": begin idx = 4; msk = 4'h6; end
      "W": begin idx = 5; msk = 4'h0; end
      "H": begin idx = 6; msk = 4'h1; end
      "J": begin idx = 7; msk = 4'h4; end
      "G": begin idx = 8; msk = 4'h2; end
      "I": begin idx = 9; msk = 4'h8; end
      default: begin idx = 0; msk = 4'h0; end
    endcase
    if (idx != 0) begin
      for (int k = 0; k < 4; k++) m_pwm[k] = msk[k] ? m_speed : 8'd0;
      r.reply = idx;
    end else if (ch == "P") begin
      m_base = 0; m_elbow = 0; r.reply = RC_HOME;
    end else if (ch == "O") r.grip = grip_open_start(p[0]);
    else if (ch == "C") r.grip = grip_close_start(p[0]);
  endtask

  // Predict the reply to one request and queue it.
  task automatic predict_reply(logic f, logic p, logic [7:0] b, logic [15:0] t);
    reply_t r;
    int st, en, pi, sum, run;
    r = '0;
    pi = p;
    if (!f) begin
      r.port = p;
      if (b == CH_LF || b == CH_CR) begin
        st = 0; en = m_len[pi];
        while (st < en && blank_ch(m_line[pi][st])) st++;
        while (en > st && blank_ch(m_line[pi][en-1])) en--;
        if (en > st) run_command(pi, st, en - st, r);
        m_len[pi] = 0;
      end else if (m_len[pi] < LINE_CAP) begin
        m_line[pi][m_len[pi]] = b;
        m_len[pi]++;
      end else begin
        m_len[pi] = 0;
        r.reply = RC_OVF;
      end
    end else begin
      r.port = m_gport;
      if (m_running) begin
        sum = m_elapsed + t;
        run = m_closing ? m_close_run : m_open_run;
        m_elapsed = (sum > 65535) ? 16'hFFFF : sum[15:0];
        if (sum > m_watchdog) begin
          m_running = 0; m_closed = m_closing;
          r.grip = m_closed ? GC_CLOSED_TO : GC_OPENED_TO;
        end else if (sum >= run) begin
          m_running = 0; m_closed = m_closing;
          r.grip = m_closed ? GC_CLOSED : GC_OPENED;
        end
      end
    end
    r.rf = m_pwm[0]; r.rb = m_pwm[1]; r.lf = m_pwm[2]; r.lb = m_pwm[3];
    r.base = m_base; r.elbow = m_elbow;
    r.drive = m_running ? (m_closing ? GD_CLOSE : GD_OPEN) : GD_STOP;
    r.closed = m_closed;
    r.speed = m_speed;
    expected_replies.push_back(r);
  endtask

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    $display("MISMATCH reply %0d: %s got %0d expected %0d", replies_seen, what, got, want);
  endtask

  // Send one request after a random gap; predict on acceptance. Valid stays up
  // after acceptance until the next request or a drain takes it down.
  task automatic send_request(logic f, logic p, logic [7:0] b, logic [15:0] t);
    int gap;
    gap = $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1; func_i <= f; source_port_i <= p;
    rx_byte_i <= b; tick_ms_i <= t;
    do @(posedge clk_i); while (!in_ready_o);
    predict_reply(f, p, b, t);
    requests_sent++;
  endtask

  task automatic send_byte(logic p, logic [7:0] b);
    send_request(1'b0, p, b, 16'($urandom));
  endtask

  task automatic send_tick(logic [15:0] t);
    send_request(1'b1, 1'($urandom), 8'($urandom), t);
  endtask

  task automatic send_line(logic p, string s);
    for (int i = 0; i < s.len(); i++) send_byte(p, s[i]);
    send_byte(p, ($urandom_range(0, 1) != 0) ? CH_CR : CH_LF);
  endtask

  // Wait until every reply is in, plus a margin for a long decode.
  task automatic drain;
    in_valid_i <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  // Valid stays up between back-to-back writes; the caller drops it.
  task automatic write_register(logic [1:0] idx, logic [15:0] val);
    cfg_valid_i <= 1'b1; cfg_index_i <= idx; cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_CLOSE_RUN) m_close_run = val;
    else if (idx == CFG_OPEN_RUN) m_open_run = val;
    else if (idx == CFG_WATCHDOG) m_watchdog = val;
  endtask

  // Receiver: random stall per reply, compare field by field.
  initial begin : reply_checker
    reply_t w;
    int gap;
    forever begin
      gap = $urandom_range(0, 12);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      replies_seen++;
      if (expected_replies.size() == 0) begin
        report_mismatch("unexpected reply", 1, 0);
      end else begin
        w = expected_replies.pop_front();
        if (reply_code_o != w.reply) report_mismatch("reply_code", reply_code_o, w.reply);
        if (grip_code_o != w.grip) report_mismatch("grip_code", grip_code_o, w.grip);
        if (reply_port_o != w.port) report_mismatch("reply_port", reply_port_o, w.port);
        if (pwm_right_fwd_o != w.rf) report_mismatch("pwm_right_fwd", pwm_right_fwd_o, w.rf);
        if (pwm_right_back_o != w.rb) report_mismatch("pwm_right_back", pwm_right_back_o, w.rb);
        if (pwm_left_fwd_o != w.lf) report_mismatch("pwm_left_fwd", pwm_left_fwd_o, w.lf);
        if (pwm_left_back_o != w.lb) report_mismatch("pwm_left_back", pwm_left_back_o, w.lb);
        if (base_angle_out_o != w.base) report_mismatch("base_angle", base_angle_out_o, w.base);
        if (elbow_angle_out_o != w.elbow)
          report_mismatch("elbow_angle", elbow_angle_out_o, w.elbow);
        if (gripper_drive_o != w.drive) report_mismatch("gripper_drive", gripper_drive_o, w.drive);
        if (gripper_is_closed_o != w.closed)
          report_mismatch("gripper_is_closed", gripper_is_closed_o, w.closed);
        if (speed_out_o != w.speed) report_mismatch("speed_out", speed_out_o, w.speed);
      end
    end
  end

  // Watchdog: cycles with no request and no reply accepted.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired after %0d idle cycles", idle_cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_drive_letters;
    string letters;
    letters = "FBLRWHJGIPX";
    for (int i = 0; i < letters.len(); i++) send_line(i[0], {" ", letters.substr(i, i), "\t"});
  endtask

  task automatic test_speed_and_arm;
    send_line(0, "SPD:300");
    send_line(1, "SPD:-5");
    send_line(0, "SPD:  +0");
    send_line(1, "F");
    send_line(0, "ARM:181,90,90");   // closes gripper
    send_line(0, "ARM:10,20");       // second comma missing
    send_line(1, "ARM:5,6,");        // nothing after second comma
    send_line(1, "ARM:,1,2");        // empty base
    send_line(0, "ARM:99999999,x,0");
    send_line(0, "");
    send_line(1, "   ");
  endtask

  task automatic test_overflow;
    for (int i = 0; i < LINE_CAP + 1; i++) send_byte(1, 8'hFF);
    send_byte(1, CH_LF);
  endtask

  task automatic test_gripper_timing;
    send_line(0, "C");
    send_line(0, "C");          // restart during a close
    send_tick(16'hFFFF);        // watchdog timeout
    send_line(1, "O");
    send_tick(16'd100);
    send_tick(16'd700);         // normal end of open run
    send_tick(16'd5);           // idle tick
  endtask

  // Mostly well-formed commands with random content, some noise.
  task automatic test_random_traffic(int n);
    string letters;
    string s;
    int k, j;
    logic p;
    letters = "FBLRWHJGIPOC";
    k = 0;
    while (k < n) begin
      p = 1'($urandom);
      case ($urandom_range(0, 9))
        0: s = $sformatf("ARM:%0d,%0d,%0d", $urandom_range(0, 250),
                         $urandom_range(0, 250), $urandom_range(0, 180));
        1: s = $sformatf("ARM:%s%0d ,%0d,%0d", ($urandom_range(0, 3) == 0) ? "-" : " ",
                         $urandom_range(0, 99999), $urandom_range(0, 200), $urandom);
        2: s = $sformatf("SPD:%0d", $urandom_range(0, 400));
        4: s = ($urandom_range(0, 1) != 0) ? "C" : "O";
        5: begin
          send_tick(16'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 600)));
          k++;
          continue;
        end
        6: begin
          send_byte(p, 8'($urandom));
          k++;
          continue;
        end
        7: s = $sformatf("ARM:%0d%0d", $urandom_range(0, 9), $urandom_range(0, 9));
        default: begin
          j = $urandom_range(0, 11);
          s = letters.substr(j, j);
        end
      endcase
      send_line(p, s);
      k += s.len() + 1;
    end
  endtask

  task automatic test_registers;
    logic [15:0] v[3];
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin v[0] = 16'd1; v[1] = 16'd1; v[2] = 16'hFFFF; end
        1: begin v[0] = 16'hFFFF; v[1] = 16'hFFFF; v[2] = 16'd1; end
        2: begin v[0] = 16'($urandom_range(1, 900)); v[1] = 16'($urandom_range(1, 900));
                 v[2] = 16'($urandom_range(300, 3000)); end
        default: begin v[0] = 16'd600; v[1] = 16'd800; v[2] = 16'd2000; end
      endcase
      for (int i = 0; i < 3; i++) write_register(i[1:0], v[i]);
      write_register(2'd3, 16'($urandom));   // ignored index
      cfg_valid_i <= 1'b0;
      test_random_traffic(150);
      drain();
    end
  endtask

  initial begin : main
    m_close_run = CLOSE_RUN_RST; m_open_run = OPEN_RUN_RST; m_watchdog = WATCHDOG_RST;
    m_len[0] = 0; m_len[1] = 0; m_speed = DRIVE_SPEED_RST;
    for (int k = 0; k < 4; k++) m_pwm[k] = 8'd0;
    m_base = 0; m_elbow = 0;
    m_closed = 0; m_running = 0; m_closing = 0; m_gport = 0; m_elapsed = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_drive_letters();
    test_speed_and_arm();
    test_overflow();
    test_gripper_timing();
    test_registers();
    test_random_traffic(900);
    drain();
    $display("Covered %0d requests and %0d replies: drive, arm, speed, overflow,",
             requests_sent, replies_seen);
    $display("gripper runs and timeouts under four register settings.");
    if (mismatches == 0 && expected_replies.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
